/* src/lfocm_pkg.sv */
// Shared types, constants and the sine table generator for the LFO channel modulator.
package lfocm_pkg;

  // Default sizes.
  localparam int unsigned GROUP_MAX       = 32;
  localparam int unsigned SINE_TABLE_BITS = 8;

  // Field and register widths.
  localparam int unsigned PHASE_W   = 24;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;
  localparam int unsigned SINE_W    = 15;

  // Offset division: spread * position * 256 has 29 bits.
  localparam int unsigned DIV_W     = 29;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W);

  // Shared multiplier operand and product widths.
  localparam int unsigned MUL_IN_W  = 17;
  localparam int unsigned MUL_OUT_W = 2 * MUL_IN_W;

  // Sine quarter-wave generation constants (Q30).
  localparam longint unsigned Q30_ONE     = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE   = 3'd0,
    REG_WAVEFORM = 3'd1,
    REG_RATE     = 3'd2,
    REG_DEPTH    = 3'd3,
    REG_SPREAD   = 3'd4
  } cfg_reg_e;

  // Waveform codes; the remaining codes give a zero wave.
  typedef enum logic [2:0] {
    WAVE_SINE     = 3'd0,
    WAVE_TRIANGLE = 3'd1,
    WAVE_SQUARE   = 3'd2,
    WAVE_SAW      = 3'd3
  } wave_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK_MUL,
    S_TICK_ADD,
    S_OFFS_MUL,
    S_DIV_INIT,
    S_DIV,
    S_PHASE,
    S_ROM,
    S_WAVE,
    S_DEPTH_MUL,
    S_SCALE,
    S_OUT
  } state_e;

  // One quarter-wave sine entry, round(32767*sin(pi/2*i/2^bits)), by a Q30 series.
  // Only ever evaluated with constant arguments, at elaboration.
  function automatic logic [SINE_W-1:0] sine_entry(input int unsigned idx,
                                                   input int unsigned bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned v;
    x  = (HALF_PI_Q30 * longint'(idx)) >> bits;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >> 30) / 110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[SINE_W-1:0];
  endfunction

endpackage

/* src/lfo_channel_modulator.sv */
// LFO channel modulator: phase accumulator, offset divider, waveform and scaling sequencer.
// Sequence: with the oscillator enabled, a tick multiplies the rate by dt, then adds the
// product to the phase; a modulate request runs the offset multiply, the divider (skipped
// for a group size of zero) and the phase, table, wave, depth and scale steps. When
// disabled, a tick is ignored and a modulate request goes straight to the output. Flow:
// one request at a time; the 29-step restoring divider for the group offset sets the pace.
// Reset: asynchronous, clears the phase, all configuration registers and the sequencer.
module lfo_channel_modulator #(
  parameter int unsigned GroupMax      = lfocm_pkg::GROUP_MAX,
  parameter int unsigned SineTableBits = lfocm_pkg::SINE_TABLE_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port
  input  logic                           cfg_we_i,
  input  logic [lfocm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [lfocm_pkg::CFG_DAT_W-1:0] cfg_data_i,
  // Request channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           kind_i,
  input  logic [15:0]                    dt_i,
  input  logic [7:0]                     base_coarse_i,
  input  logic [7:0]                     base_fine_i,
  input  logic                           wide_i,
  input  logic [4:0]                     group_position_i,
  input  logic [5:0]                     group_size_i,
  // Result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     value_coarse_o,
  output logic [7:0]                     value_fine_o
);
  import lfocm_pkg::*;

  localparam int unsigned RomEntries = (1 << SineTableBits) + 1;
  localparam int unsigned RomIdxW    = SineTableBits + 1;

  // Constant quarter-wave sine table.
  logic [SINE_W-1:0] sine_rom [RomEntries];
  for (genvar g = 0; g < RomEntries; g++) begin : g_rom
    assign sine_rom[g] = sine_entry(g, SineTableBits);
  end

  // Control state.
  state_e               state_q, state_d;
  logic                 enable_q;
  logic [2:0]           waveform_q;
  logic [15:0]          rate_q;
  logic [8:0]           depth_q;
  logic [15:0]          spread_q;
  logic [PHASE_W-1:0]   phase_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 out_valid_q;

  // Request and datapath registers.
  logic [15:0]          dt_q;
  logic [7:0]           bc_q;
  logic [7:0]           bf_q;
  logic                 wide_q;
  logic [4:0]           pos_q;
  logic [5:0]           size_q;
  logic                 bypass_q;
  logic [MUL_OUT_W-1:0] mul_q;
  logic [DIV_W-1:0]     div_q;
  logic [5:0]           rem_q;
  logic [PHASE_W-1:0]   p_q;
  logic [SINE_W-1:0]    rom_q;
  logic signed [15:0]   w_q;
  logic signed [16:0]   adj_q;
  logic [7:0]           value_coarse_q;
  logic [7:0]           value_fine_q;

  // Sequencer outputs.
  logic                 in_acc;
  logic                 out_load;
  logic signed [MUL_IN_W-1:0] mul_a, mul_b;

  assign in_acc = in_valid_i && in_ready_o;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (!kind_i) begin
            state_d = enable_q ? S_TICK_MUL : S_IDLE;
          end else begin
            state_d = enable_q ? S_OFFS_MUL : S_OUT;
          end
        end
      end
      S_TICK_MUL:  state_d = S_TICK_ADD;
      S_TICK_ADD:  state_d = S_IDLE;
      S_OFFS_MUL:  state_d = S_DIV_INIT;
      S_DIV_INIT:  state_d = (size_q == 6'd0) ? S_PHASE : S_DIV;
      S_DIV: begin
        if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
          state_d = S_PHASE;
        end
      end
      S_PHASE:     state_d = S_ROM;
      S_ROM:       state_d = S_WAVE;
      S_WAVE:      state_d = S_DEPTH_MUL;
      S_DEPTH_MUL: state_d = S_SCALE;
      S_SCALE:     state_d = S_OUT;
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default:     state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and multiplier operand selection.
  always_comb begin
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state_q)
      S_IDLE:      in_ready_o = 1'b1;
      S_TICK_MUL: begin
        mul_a = {1'b0, rate_q};
        mul_b = {1'b0, dt_q};
      end
      S_OFFS_MUL: begin
        mul_a = {1'b0, spread_q};
        mul_b = {12'd0, pos_q};
      end
      S_DEPTH_MUL: begin
        mul_a = {w_q[15], w_q};
        mul_b = (depth_q > 9'd256) ? 17'sd256 : {8'd0, depth_q};
      end
      S_OUT:       out_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  // Shared multiplier.
  logic signed [MUL_OUT_W-1:0] mul_prod;
  assign mul_prod = mul_a * mul_b;

  // Divider step: shift in one dividend bit, subtract the size if it fits.
  logic [6:0] div_trial;
  logic       div_ge;
  logic [6:0] div_rem;
  assign div_trial = {rem_q, div_q[DIV_W-1]};
  assign div_ge    = div_trial >= {1'b0, size_q};
  assign div_rem   = div_ge ? (div_trial - {1'b0, size_q}) : div_trial;

  // Quarter-wave table address, mirrored in odd quadrants.
  logic [SineTableBits-1:0] rom_raw;
  logic [RomIdxW-1:0]       rom_idx;
  assign rom_raw = p_q[PHASE_W-3 -: SineTableBits];
  assign rom_idx = p_q[PHASE_W-2] ? (RomIdxW'(RomEntries - 1) - {1'b0, rom_raw})
                                  : {1'b0, rom_raw};

  // Waveform value in signed Q1.15.
  logic signed [15:0] wave_val;
  logic [15:0]        tri_x;
  logic [15:0]        sine_mag;
  assign tri_x    = p_q[22:7];
  assign sine_mag = {1'b0, rom_q};
  always_comb begin
    wave_val = '0;
    case (waveform_q)
      WAVE_SINE: begin
        wave_val = p_q[PHASE_W-1] ? -$signed(sine_mag) : $signed(sine_mag);
      end
      WAVE_TRIANGLE: begin
        if (!p_q[PHASE_W-1]) begin
          wave_val = {~tri_x[15], tri_x[14:0]};
        end else if (tri_x == 16'd0) begin
          wave_val = 16'sd32767;
        end else begin
          wave_val = $signed(16'(17'd32768 - {1'b0, tri_x}));
        end
      end
      WAVE_SQUARE: wave_val = p_q[PHASE_W-1] ? -16'sd32768 : 16'sd32767;
      WAVE_SAW:    wave_val = {~p_q[23], p_q[22:8]};
      default:     wave_val = '0;
    endcase
  end

  // Scale by 255 or 65535 and floor-divide by 2^24.
  logic signed [24:0] scl_m;
  logic signed [40:0] scl_ext;
  logic signed [40:0] scl_sh;
  logic signed [40:0] scl_diff;
  assign scl_m    = $signed(mul_q[24:0]);
  assign scl_ext  = 41'(scl_m);
  assign scl_sh   = wide_q ? (scl_ext <<< 16) : (scl_ext <<< 8);
  assign scl_diff = scl_sh - scl_ext;

  // Add the base and saturate.
  logic [15:0]        sum_base;
  logic signed [17:0] sum_r;
  logic [15:0]        sum_sat;
  assign sum_base = wide_q ? {bc_q, bf_q} : {8'd0, bc_q};
  assign sum_r    = $signed({2'b00, sum_base}) + 18'(adj_q);
  always_comb begin
    if (sum_r < 18'sd0) begin
      sum_sat = '0;
    end else if (wide_q && sum_r > 18'sd65535) begin
      sum_sat = 16'hFFFF;
    end else if (!wide_q && sum_r > 18'sd255) begin
      sum_sat = 16'h00FF;
    end else begin
      sum_sat = sum_r[15:0];
    end
  end

  // Configuration registers and phase accumulator.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b0;
      waveform_q <= '0;
      rate_q     <= '0;
      depth_q    <= '0;
      spread_q   <= '0;
      phase_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ENABLE: begin
          if (cfg_data_i[0] && !enable_q) begin
            phase_q <= '0;
          end
          enable_q <= cfg_data_i[0];
        end
        REG_WAVEFORM: waveform_q <= cfg_data_i[2:0];
        REG_RATE:     rate_q     <= cfg_data_i;
        REG_DEPTH:    depth_q    <= cfg_data_i[8:0];
        REG_SPREAD:   spread_q   <= cfg_data_i;
        default: ;
      endcase
    end else if (state_q == S_TICK_ADD) begin
      phase_q <= phase_q + mul_q[PHASE_W-1:0];
    end
  end

  // Sequencer state, step counter and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DIV_INIT) begin
        cnt_q <= '0;
      end else if (state_q == S_DIV) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dt_q     <= dt_i;
      bc_q     <= base_coarse_i;
      bf_q     <= base_fine_i;
      wide_q   <= wide_i;
      pos_q    <= group_position_i;
      size_q   <= (group_size_i > 6'(GroupMax)) ? 6'(GroupMax) : group_size_i;
      bypass_q <= !enable_q;
    end
    if (state_q == S_TICK_MUL || state_q == S_OFFS_MUL || state_q == S_DEPTH_MUL) begin
      mul_q <= mul_prod;
    end
    if (state_q == S_DIV_INIT) begin
      div_q <= (size_q == 6'd0) ? '0 : {mul_q[20:0], 8'd0};
      rem_q <= '0;
    end else if (state_q == S_DIV) begin
      div_q <= {div_q[DIV_W-2:0], div_ge};
      rem_q <= div_rem[5:0];
    end
    if (state_q == S_PHASE) begin
      p_q <= phase_q + div_q[PHASE_W-1:0];
    end
    if (state_q == S_ROM) begin
      rom_q <= sine_rom[rom_idx];
    end
    if (state_q == S_WAVE) begin
      w_q <= wave_val;
    end
    if (state_q == S_SCALE) begin
      adj_q <= scl_diff[40:24];
    end
    if (out_load) begin
      if (bypass_q) begin
        value_coarse_q <= bc_q;
        value_fine_q   <= wide_q ? bf_q : 8'd0;
      end else if (wide_q) begin
        value_coarse_q <= sum_sat[15:8];
        value_fine_q   <= sum_sat[7:0];
      end else begin
        value_coarse_q <= sum_sat[7:0];
        value_fine_q   <= 8'd0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign value_coarse_o = value_coarse_q;
  assign value_fine_o   = value_fine_q;

endmodule

/* tb/lfo_channel_modulator_tb.sv */
// Testbench for the LFO channel modulator: directed and random requests checked by a predictor.
module lfo_channel_modulator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lfocm_pkg::*;

  localparam int unsigned CLK_HALF      = 4;
  localparam longint     MAX_CYCLES    = 3_000_000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES   = 60;
  localparam int unsigned WAVE_CODES    = 8;
  localparam int unsigned DEPTH_FULL    = 256;

  // Request kinds.
  localparam logic KIND_TICK     = 1'b0;
  localparam logic KIND_MODULATE = 1'b1;

  // Fixed-point constants for the quarter-wave sine table.
  localparam int unsigned     QUARTER_STEPS = 1 << SINE_TABLE_BITS;
  localparam longint unsigned FIX_ONE       = 64'd1 << 30;
  localparam longint unsigned HALF_PI_FIX   = 64'd1686629713;

  typedef struct packed {
    logic [7:0] coarse;
    logic [7:0] fine;
  } chan_value_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        kind_i;
  logic [15:0] dt_i;
  logic [7:0]  base_coarse_i;
  logic [7:0]  base_fine_i;
  logic        wide_i;
  logic [4:0]  group_position_i;
  logic [5:0]  group_size_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  value_coarse_o;
  logic [7:0]  value_fine_o;

  // Oscillator state as the predictor sees it.
  logic [23:0] lfo_phase;
  logic        lfo_enable;
  logic [2:0]  lfo_wave;
  logic [15:0] lfo_rate;
  logic [8:0]  lfo_depth;
  logic [15:0] lfo_spread;
  logic [14:0] sine_quarter [0:QUARTER_STEPS];

  chan_value_t expected_values[$];

  int unsigned source_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned error_count;
  int unsigned tick_count;
  int unsigned modulate_count;
  int unsigned results_checked;
  int unsigned cfg_write_count;
  longint      cycle_count;

  lfo_channel_modulator dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .dt_i             (dt_i),
    .base_coarse_i    (base_coarse_i),
    .base_fine_i      (base_fine_i),
    .wide_i           (wide_i),
    .group_position_i (group_position_i),
    .group_size_i     (group_size_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .value_coarse_o   (value_coarse_o),
    .value_fine_o     (value_fine_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  // Quarter-wave sine amplitude, rounded to 15 bits, from a fixed-point Taylor series.
  function automatic logic [14:0] quarter_sine(input int unsigned step);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned v;
    x  = (HALF_PI_FIX * 64'(step)) / QUARTER_STEPS;
    x2 = (x * x) >> 30;
    t  = FIX_ONE;
    for (int k = 10; k >= 2; k -= 2) begin
      t = FIX_ONE - ((x2 * t) >> 30) / 64'(k * (k + 1));
    end
    s = (x * t) >> 30;
    v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[14:0];
  endfunction

  // Signed Q1.15 wave value at phase p for the current waveform.
  function automatic int wave_sample(input logic [23:0] p);
    int unsigned step;
    int          v;
    case (lfo_wave)
      WAVE_SINE: begin
        step = (p >> (22 - SINE_TABLE_BITS)) & (QUARTER_STEPS - 1);
        if (p[22]) begin
          step = QUARTER_STEPS - step;
        end
        v = int'(sine_quarter[step]);
        return p[23] ? -v : v;
      end
      WAVE_TRIANGLE: begin
        if (!p[23]) begin
          v = int'(p >> 7) - 32768;
        end else begin
          v = 98304 - int'(p >> 7);
        end
        if (v > 32767) begin
          v = 32767;
        end
        if (v < -32768) begin
          v = -32768;
        end
        return v;
      end
      WAVE_SQUARE: return p[23] ? -32768 : 32767;
      WAVE_SAW:    return int'(p >> 8) - 32768;
      default:     return 0;
    endcase
  endfunction

  // Expected channel value for one modulate request.
  function automatic chan_value_t predict_modulate(input logic [7:0] bc, input logic [7:0] bf,
                                                   input logic wide, input logic [4:0] pos,
                                                   input logic [5:0] size);
    chan_value_t     res;
    longint unsigned offset;
    int unsigned     group;
    logic [23:0]     p;
    longint          w;
    longint          d;
    longint          base;
    longint          r;
    if (!lfo_enable) begin
      res.coarse = bc;
      res.fine   = wide ? bf : 8'd0;
      return res;
    end
    group  = (size > GROUP_MAX) ? GROUP_MAX : size;
    offset = (group == 0) ? 64'd0 : (64'(lfo_spread) * 64'd256 * 64'(pos)) / group;
    p      = 24'(64'(lfo_phase) + offset);
    w      = wave_sample(p);
    d      = (lfo_depth > DEPTH_FULL) ? DEPTH_FULL : lfo_depth;
    if (wide) begin
      base = {bc, bf};
      r    = base + ((w * d * 65535) >>> 24);
      if (r < 0) begin
        r = 0;
      end
      if (r > 65535) begin
        r = 65535;
      end
      res.coarse = r[15:8];
      res.fine   = r[7:0];
    end else begin
      base = bc;
      r    = base + ((w * d * 255) >>> 24);
      if (r < 0) begin
        r = 0;
      end
      if (r > 255) begin
        r = 255;
      end
      res.coarse = r[7:0];
      res.fine   = 8'd0;
    end
    return res;
  endfunction

  // Predictor side of a register write.
  function automatic void apply_reg(input cfg_reg_e idx, input logic [15:0] data);
    case (idx)
      REG_ENABLE: begin
        if (data[0] && !lfo_enable) begin
          lfo_phase = '0;
        end
        lfo_enable = data[0];
      end
      REG_WAVEFORM: lfo_wave   = data[2:0];
      REG_RATE:     lfo_rate   = data;
      REG_DEPTH:    lfo_depth  = data[8:0];
      REG_SPREAD:   lfo_spread = data;
      default: ;
    endcase
  endfunction

  // Mostly random bytes, with the two extremes favored.
  function automatic logic [7:0] biased_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] biased_word();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Write one register while the block is idle.
  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    apply_reg(idx, data);
    cfg_write_count++;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Program every register, enable last so a fresh enable clears the phase.
  task automatic program_lfo(input logic en, input logic [2:0] wave, input logic [15:0] rate,
                             input logic [8:0] depth, input logic [15:0] spread);
    write_reg(REG_WAVEFORM, 16'(wave));
    write_reg(REG_RATE, rate);
    write_reg(REG_DEPTH, 16'(depth));
    write_reg(REG_SPREAD, spread);
    write_reg(REG_ENABLE, 16'(en));
  endtask

  // Send one request; valid is held until a later call or a drain lowers it.
  task automatic send_request(input logic kind, input logic [15:0] dt, input logic [7:0] bc,
                              input logic [7:0] bf, input logic wide, input logic [4:0] pos,
                              input logic [5:0] size);
    @(negedge clk_i);
    while ($urandom_range(99) < source_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    kind_i           = kind;
    dt_i             = dt;
    base_coarse_i    = bc;
    base_fine_i      = bf;
    wide_i           = wide;
    group_position_i = pos;
    group_size_i     = size;
    in_valid_i       = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (kind == KIND_TICK) begin
      if (lfo_enable) begin
        lfo_phase = 24'(64'(lfo_phase) + 64'(lfo_rate) * 64'(dt));
      end
      tick_count++;
    end else begin
      expected_values.push_back(predict_modulate(bc, bf, wide, pos, size));
      modulate_count++;
    end
  endtask

  // Hold off the sender until every expected result has arrived, then let the block settle.
  task automatic wait_results_drained(input int unsigned settle);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_values.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic set_idling(input int unsigned source_pct, input int unsigned sink_pct);
    source_idle_pct = source_pct;
    sink_stall_pct  = sink_pct;
  endtask

  // With the oscillator off, the base passes straight through and ticks are ignored.
  task automatic test_disabled_passthrough();
    program_lfo(1'b0, WAVE_SQUARE, 16'hFFFF, 9'd256, 16'hFFFF);
    send_request(KIND_MODULATE, 16'h0000, 8'hFF, 8'hFF, 1'b0, 5'd31, 6'd32);
    send_request(KIND_MODULATE, 16'h0000, 8'hFF, 8'hFF, 1'b1, 5'd31, 6'd32);
    send_request(KIND_TICK, 16'hFFFF, 8'h00, 8'h00, 1'b0, 5'd0, 6'd1);
    send_request(KIND_MODULATE, 16'hFFFF, 8'h00, 8'h00, 1'b1, 5'd0, 6'd0);
    send_request(KIND_MODULATE, 16'hFFFF, 8'h00, 8'hFF, 1'b0, 5'd0, 6'd63);
    wait_results_drained(SETTLE_CYCLES);
  endtask

  // Every waveform code, including the ones that give a zero wave.
  task automatic test_waveform_codes();
    program_lfo(1'b1, WAVE_SINE, 16'd4096, 9'd256, 16'd0);
    for (int code = 0; code < WAVE_CODES; code++) begin
      write_reg(REG_WAVEFORM, 16'(code));
      send_request(KIND_MODULATE, 16'h0000, 8'h80, 8'h00, 1'b1, 5'd0, 6'd1);
      if (code % 2 == 1) begin
        send_request(KIND_TICK, 16'h1F3D, 8'h00, 8'h00, 1'b0, 5'd0, 6'd1);
      end
      wait_results_drained(SETTLE_CYCLES);
    end
  endtask

  // Depth clamp, group size corner values, offset wrap and enable toggling.
  task automatic test_special_cases();
    program_lfo(1'b1, WAVE_SQUARE, 16'hFFFF, 9'd511, 16'hFFFF);
    send_request(KIND_MODULATE, 16'h0000, 8'hFF, 8'h00, 1'b0, 5'd0, 6'd1);
    send_request(KIND_MODULATE, 16'h0000, 8'h00, 8'h00, 1'b1, 5'd31, 6'd0);
    send_request(KIND_MODULATE, 16'h0000, 8'h80, 8'h00, 1'b0, 5'd31, 6'd63);
    send_request(KIND_MODULATE, 16'h0000, 8'hC8, 8'h07, 1'b1, 5'd31, 6'd1);
    send_request(KIND_TICK, 16'hFFFF, 8'h00, 8'h00, 1'b0, 5'd0, 6'd1);
    send_request(KIND_TICK, 16'h0000, 8'h00, 8'h00, 1'b0, 5'd0, 6'd1);
    send_request(KIND_MODULATE, 16'h0000, 8'h00, 8'hFF, 1'b1, 5'd7, 6'd9);
    wait_results_drained(SETTLE_CYCLES);
    // Disabling keeps the phase, and enabling again clears it.
    write_reg(REG_ENABLE, 16'd0);
    send_request(KIND_MODULATE, 16'h0000, 8'h5A, 8'hA5, 1'b1, 5'd3, 6'd4);
    wait_results_drained(SETTLE_CYCLES);
    write_reg(REG_WAVEFORM, 16'(WAVE_SAW));
    write_reg(REG_ENABLE, 16'd1);
    send_request(KIND_MODULATE, 16'h0000, 8'h80, 8'h00, 1'b1, 5'd0, 6'd1);
    wait_results_drained(SETTLE_CYCLES);
  endtask

  // Pick a fresh register setting, the extremes included.
  task automatic randomize_lfo();
    logic [2:0]  wave_v;
    logic [15:0] rate_v;
    logic [8:0]  depth_v;
    logic        enable_v;
    wave_v   = ($urandom_range(9) < 8) ? 3'($urandom_range(3)) : 3'($urandom_range(7));
    rate_v   = biased_word();
    case ($urandom_range(5))
      0:       depth_v = 9'd0;
      1:       depth_v = 9'd256;
      2:       depth_v = 9'd511;
      3:       depth_v = 9'($urandom_range(511));
      default: depth_v = 9'($urandom_range(256));
    endcase
    enable_v = ($urandom_range(7) != 0);
    if (enable_v && $urandom_range(1) == 1) begin
      write_reg(REG_ENABLE, 16'd0);
    end
    program_lfo(enable_v, wave_v, rate_v, depth_v, biased_word());
  endtask

  // Rounds of mixed ticks and modulate requests, each round under a new setting.
  task automatic run_random_rounds(input int unsigned rounds, input int unsigned per_round);
    logic        kind;
    logic [5:0]  size;
    for (int r = 0; r < rounds; r++) begin
      wait_results_drained(SETTLE_CYCLES);
      randomize_lfo();
      for (int n = 0; n < per_round; n++) begin
        kind = ($urandom_range(99) < 40) ? KIND_TICK : KIND_MODULATE;
        size = ($urandom_range(9) == 0) ? 6'($urandom_range(63))
                                        : 6'($urandom_range(GROUP_MAX, 1));
        send_request(kind, biased_word(), biased_byte(), biased_byte(), 1'($urandom_range(1)),
                     5'($urandom_range(31)), size);
        // Now and then the sender waits until every expected result has arrived.
        if ($urandom_range(49) == 0) begin
          wait_results_drained(0);
        end
      end
    end
  endtask

  task automatic test_random_sink_stalls();
    set_idling(16, 63);
    run_random_rounds(10, 65);
  endtask

  task automatic test_random_source_gaps();
    set_idling(63, 16);
    run_random_rounds(10, 65);
  endtask

  task automatic test_random_full_rate();
    set_idling(0, 0);
    run_random_rounds(10, 65);
  endtask

  // Receiver readiness changes at the falling edge.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Compare each accepted result with the oldest expected value.
  always @(posedge clk_i) begin
    chan_value_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_checked++;
      if (expected_values.size() == 0) begin
        error_count++;
        $display("%0t: result with none expected, actual coarse=%0d fine=%0d",
                 $time, value_coarse_o, value_fine_o);
      end else begin
        want = expected_values.pop_front();
        if ({value_coarse_o, value_fine_o} !== want) begin
          error_count++;
          $display("%0t: value mismatch, expected coarse=%0d fine=%0d, actual coarse=%0d fine=%0d",
                   $time, want.coarse, want.fine, value_coarse_o, value_fine_o);
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= MAX_CYCLES) begin
      $display("lfo_channel_modulator_tb: errors");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i <= QUARTER_STEPS; i++) begin
      sine_quarter[i] = quarter_sine(i);
    end
    lfo_phase        = '0;
    lfo_enable       = 1'b0;
    lfo_wave         = '0;
    lfo_rate         = '0;
    lfo_depth        = '0;
    lfo_spread       = '0;
    error_count      = 0;
    tick_count       = 0;
    modulate_count   = 0;
    results_checked  = 0;
    cfg_write_count  = 0;
    cycle_count      = 0;
    source_idle_pct  = 0;
    sink_stall_pct   = 0;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_index_i      = REG_ENABLE;
    cfg_data_i       = '0;
    in_valid_i       = 1'b0;
    kind_i           = KIND_TICK;
    dt_i             = '0;
    base_coarse_i    = '0;
    base_fine_i      = '0;
    wide_i           = 1'b0;
    group_position_i = '0;
    group_size_i     = '0;
    out_ready_i      = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_disabled_passthrough();
    test_waveform_codes();
    test_special_cases();
    test_random_sink_stalls();
    test_random_source_gaps();
    test_random_full_rate();

    wait_results_drained(TAIL_CYCLES);
    $display("Run covered %0d requests (%0d ticks, %0d modulates) and %0d register writes;",
             tick_count + modulate_count, tick_count, modulate_count, cfg_write_count);
    $display("%0d results were checked under sender gaps, receiver stalls and full rate.",
             results_checked);
    if (error_count == 0 && expected_values.size() == 0) begin
      $display("lfo_channel_modulator_tb: clean");
    end else begin
      $display("lfo_channel_modulator_tb: errors");
    end
    $finish;
  end

endmodule

/* files.f */
src/lfocm_pkg.sv
src/lfo_channel_modulator.sv
tb/lfo_channel_modulator_tb.sv
